// ===== rtl/mvng_pkg.sv =====
package mvng_pkg;

   // command codes on req_cmd
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_LOAD_POS  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_FACE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

   // default store depths
   localparam int MAX_VERTS_DEFAULT = 256;
   localparam int MAX_FACES_DEFAULT = 512;

   // field widths
   localparam int SLOT_W   = 9;
   localparam int VIDX_W   = 8;
   localparam int POS_W    = 16;
   localparam int NORM_W   = 16;
   localparam int CORNER_W = 2;

   // datapath widths
   localparam int EDGE_W   = POS_W + 1;       // difference of two positions
   localparam int MUL_W    = 22;              // shared multiplier operand
   localparam int PROD_W   = 2 * MUL_W;
   localparam int CROSS_W  = 35;              // cross product component
   localparam int ABS_W    = CROSS_W - 1;
   localparam int NRM_TOP  = 20;              // normalized range [2^19, 2^20)
   localparam int FRAC_W   = 14;              // Q1.14
   localparam int SQ_W     = 44;              // sum of squares
   localparam int ROOT_W   = SQ_W / 2;
   localparam int QUO_W    = 16;              // quotients stay below 2^16
   localparam int FDVD_W   = ABS_W + 1;       // face divide dividend

   // shared unit operations
   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_SQRT = 2'd1,
      ALU_DIV  = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

endpackage

// ===== rtl/mvng_ram.sv =====
module mvng_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mvng_alu.sv =====
module mvng_alu import mvng_pkg::*; #(
   parameter int DVD_W = 35,
   parameter int DVS_W = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  alu_ctl_type              ctl,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   input  logic [SQ_W-1:0]          sq_in,
   input  logic [DVD_W-1:0]         dividend,
   input  logic [DVS_W-1:0]         divisor,
   output logic signed [PROD_W-1:0] prod,
   output logic [ROOT_W-1:0]        root,
   output logic [QUO_W-1:0]         quot,
   output logic                     done
);

   localparam int CNT_W = $clog2(QUO_W);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SQ_W-1:0]  sv_ff, sv_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUO_W-1:0] lo_ff, lo_in, quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sq_busy_ff, sq_busy_in, dv_busy_ff, dv_busy_in, done_ff, done_in;

   logic [SQ_W-1:0]  trial;
   logic             take;
   logic [DVS_W:0]   part;
   logic [DVS_W:0]   diff;
   logic             ge;

   // one root bit per cycle, one quotient bit per cycle
   always_comb begin
      trial = sr_ff + sb_ff;
      take  = (sv_ff >= trial);
      part  = {rem_ff, lo_ff[QUO_W-1]};
      diff  = part - {1'b0, dvs_ff};
      ge    = (part >= {1'b0, dvs_ff});

      prod_in    = prod_ff;
      sv_in      = sv_ff;
      sr_in      = sr_ff;
      sb_in      = sb_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      lo_in      = lo_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      sq_busy_in = sq_busy_ff;
      dv_busy_in = dv_busy_ff;
      done_in    = 1'b0;

      if (ctl.start) begin
         case (ctl.op)
            ALU_MUL: begin
               prod_in = mul_a * mul_b;
            end
            ALU_SQRT: begin
               sv_in      = sq_in;
               sr_in      = '0;
               sb_in      = SQ_W'(1) << (SQ_W - 2);
               sq_busy_in = 1'b1;
            end
            ALU_DIV: begin
               rem_in     = DVS_W'(dividend >> QUO_W);
               lo_in      = dividend[QUO_W-1:0];
               dvs_in     = divisor;
               quo_in     = '0;
               cnt_in     = CNT_W'(QUO_W - 1);
               dv_busy_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (sq_busy_ff) begin
         if (take) begin
            sv_in = sv_ff - trial;
            sr_in = (sr_ff >> 1) + sb_ff;
         end else begin
            sr_in = sr_ff >> 1;
         end
         sb_in = sb_ff >> 2;
         if (sb_ff == SQ_W'(1)) begin
            sq_busy_in = 1'b0;
            done_in    = 1'b1;
         end
      end

      if (dv_busy_ff) begin
         rem_in = ge ? DVS_W'(diff) : DVS_W'(part);
         quo_in = {quo_ff[QUO_W-2:0], ge};
         lo_in  = lo_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            dv_busy_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         dv_busy_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         sq_busy_ff <= sq_busy_in;
         dv_busy_ff <= dv_busy_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sv_ff   <= sv_in;
      sr_ff   <= sr_in;
      sb_ff   <= sb_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      lo_ff   <= lo_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   assign prod = prod_ff;
   assign root = sr_ff[ROOT_W-1:0];
   assign quot = quo_ff;
   assign done = done_ff;

endmodule

// ===== rtl/mesh_vertex_normal_generator_core.sv =====
// Loads (position, face) are accepted one per cycle, back to back.
// Face read: each corner's normal is read and registered, then held until the response handshake.
// Compute: clears the accumulator of every loaded vertex, then processes each face
// and averages each vertex, using the shared multiplier, square root and divider.
// Reset clears the vertex and face counts; the stores are not cleared.
module mesh_vertex_normal_generator_core import mvng_pkg::*; #(
   parameter int MAX_VERTS = MAX_VERTS_DEFAULT,
   parameter int MAX_FACES = MAX_FACES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [SLOT_W-1:0]        req_slot,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic [VIDX_W-1:0]        req_corner_a,
   input  logic [VIDX_W-1:0]        req_corner_b,
   input  logic [VIDX_W-1:0]        req_corner_c,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CORNER_W-1:0]      rsp_corner,
   output logic signed [NORM_W-1:0] rsp_norm_x,
   output logic signed [NORM_W-1:0] rsp_norm_y,
   output logic signed [NORM_W-1:0] rsp_norm_z,
   output logic                     rsp_last,
   output logic                     rsp_done_res,
   output logic                     rsp_error
);

   localparam int VW    = $clog2(MAX_VERTS);
   localparam int FW    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int VCW   = $clog2(MAX_VERTS + 1);
   localparam int FCW   = $clog2(MAX_FACES + 1);
   localparam int CNTW  = FCW;
   localparam int SUMW  = CNTW + FRAC_W + 1;
   localparam int ACCW  = 3 * SUMW + CNTW;
   localparam int DVD_W = (FDVD_W > SUMW) ? FDVD_W : SUMW;
   localparam int DVS_W = (ROOT_W > CNTW) ? ROOT_W : CNTW;
   localparam int PW    = 3 * POS_W;
   localparam int NW    = 3 * NORM_W;
   localparam int FDW   = 3 * VIDX_W;

   typedef enum logic [19:0] {
      ST_IDLE    = 20'h00001,
      ST_CLR     = 20'h00002,
      ST_F_ISSUE = 20'h00004,
      ST_F_WAIT  = 20'h00008,
      ST_P_READ  = 20'h00010,
      ST_MUL     = 20'h00020,
      ST_ABS     = 20'h00040,
      ST_NORM    = 20'h00080,
      ST_SQ      = 20'h00100,
      ST_SQRT    = 20'h00200,
      ST_DIVF    = 20'h00400,
      ST_ACC_RD  = 20'h00800,
      ST_ACC_WR  = 20'h01000,
      ST_V_ISSUE = 20'h02000,
      ST_V_WAIT  = 20'h04000,
      ST_V_DIV   = 20'h08000,
      ST_R_FACE  = 20'h10000,
      ST_R_ISSUE = 20'h20000,
      ST_R_WAIT  = 20'h40000,
      ST_RSP     = 20'h80000
   } state_type;

   // control
   state_type        state_ff, state_in;
   logic [VCW-1:0]   vcount_ff, vcount_in, v_ff, v_in;
   logic [FCW-1:0]   fcount_ff, fcount_in, f_ff, f_in;
   logic [1:0]       k_ff, k_in;
   logic [2:0]       j_ff, j_in;
   logic             wait_ff, wait_in, err_ff, err_in, more_ff, more_in;

   // face datapath
   logic [VIDX_W-1:0]         idx_ff [3], idx_in [3];
   logic signed [POS_W-1:0]   p0_ff [3], p0_in [3];
   logic signed [EDGE_W-1:0]  e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [CROSS_W-1:0] c_ff [3], c_in [3];
   logic [ABS_W-1:0]          a_ff [3], a_in [3];
   logic [ABS_W-1:0]          m_ff, m_in;
   logic [2:0]                neg_ff, neg_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [ROOT_W-1:0]         len_ff, len_in;
   logic signed [NORM_W-1:0]  u_ff [3], u_in [3];
   logic signed [SUMW-1:0]    sum_ff [3], sum_in [3];
   logic [CNTW-1:0]           n_ff, n_in;

   // result register
   logic [CORNER_W-1:0]       rc_ff, rc_in;
   logic signed [NORM_W-1:0]  rn_ff [3], rn_in [3];
   logic                      rl_ff, rl_in, rd_ff, rd_in, re_ff, re_in;

   // memories
   logic             pos_we, pos_re, face_we, face_re, acc_we, acc_re, nrm_we, nrm_re;
   logic [VW-1:0]    pos_waddr, pos_raddr, acc_waddr, acc_raddr, nrm_waddr, nrm_raddr;
   logic [FW-1:0]    face_waddr, face_raddr;
   logic [PW-1:0]    pos_wdata, pos_rdata;
   logic [FDW-1:0]   face_wdata, face_rdata;
   logic [ACCW-1:0]  acc_wdata, acc_rdata;
   logic [NW-1:0]    nrm_wdata, nrm_rdata;

   // shared unit
   alu_ctl_type              alu_ctl;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic [DVD_W-1:0]         dvd;
   logic [DVS_W-1:0]         dvs;
   logic signed [PROD_W-1:0] prod;
   logic [ROOT_W-1:0]        root;
   logic [QUO_W-1:0]         quot;
   logic                     alu_done;

   // helpers
   logic signed [POS_W-1:0]   pv [3];
   logic [VIDX_W-1:0]         fc [3];
   logic signed [SUMW-1:0]    as [3];
   logic [CNTW-1:0]           an;
   logic [VIDX_W-1:0]         idx_sel;
   logic [ABS_W-1:0]          a_sel, m_new;
   logic                      neg_sel, bad, dup;
   logic signed [SUMW-1:0]    s_sel;
   logic [SUMW-1:0]           s_abs;
   logic signed [CROSS_W-1:0] pc;
   logic signed [NORM_W-1:0]  qs, qv;
   logic [ABS_W-1:0]          ca [3];

   mvng_ram #(.WIDTH(PW), .DEPTH(MAX_VERTS), .AW(VW)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata));

   mvng_ram #(.WIDTH(FDW), .DEPTH(MAX_FACES), .AW(FW)) u_face_ram (
      .clock(clock), .we(face_we), .waddr(face_waddr), .wdata(face_wdata),
      .re(face_re), .raddr(face_raddr), .rdata(face_rdata));

   mvng_ram #(.WIDTH(ACCW), .DEPTH(MAX_VERTS), .AW(VW)) u_acc_ram (
      .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
      .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata));

   mvng_ram #(.WIDTH(NW), .DEPTH(MAX_VERTS), .AW(VW)) u_nrm_ram (
      .clock(clock), .we(nrm_we), .waddr(nrm_waddr), .wdata(nrm_wdata),
      .re(nrm_re), .raddr(nrm_raddr), .rdata(nrm_rdata));

   mvng_alu #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_alu (
      .clock(clock), .reset(reset), .ctl(alu_ctl), .mul_a(mul_a), .mul_b(mul_b),
      .sq_in(sq_ff), .dividend(dvd), .divisor(dvs), .prod(prod), .root(root),
      .quot(quot), .done(alu_done));

   // unpack memory words and pick operands
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv[i] = pos_rdata[PW-1-i*POS_W -: POS_W];
         fc[i] = face_rdata[FDW-1-i*VIDX_W -: VIDX_W];
         as[i] = acc_rdata[ACCW-1-i*SUMW -: SUMW];
         ca[i] = c_ff[i][CROSS_W-1] ? ABS_W'(-c_ff[i]) : ABS_W'(c_ff[i]);
      end
      an = acc_rdata[CNTW-1:0];

      case (k_ff)
         2'd0:    idx_sel = idx_ff[0];
         2'd1:    idx_sel = idx_ff[1];
         default: idx_sel = idx_ff[2];
      endcase

      case (j_ff)
         3'd0: begin
            a_sel = a_ff[0]; neg_sel = neg_ff[0]; s_sel = sum_ff[0];
         end
         3'd1: begin
            a_sel = a_ff[1]; neg_sel = neg_ff[1]; s_sel = sum_ff[1];
         end
         default: begin
            a_sel = a_ff[2]; neg_sel = neg_ff[2]; s_sel = sum_ff[2];
         end
      endcase

      s_abs = s_sel[SUMW-1] ? SUMW'(-s_sel) : SUMW'(s_sel);
      qs    = $signed(quot);
      qv    = neg_sel ? -qs : qs;
      pc    = CROSS_W'(prod);

      m_new = ca[0];
      if (ca[1] > m_new) m_new = ca[1];
      if (ca[2] > m_new) m_new = ca[2];

      bad = (32'(fc[0]) >= 32'(vcount_ff)) || (32'(fc[1]) >= 32'(vcount_ff))
         || (32'(fc[2]) >= 32'(vcount_ff));
      dup = ((k_ff == 2'd1) && (idx_ff[1] == idx_ff[0]))
         || ((k_ff == 2'd2) && ((idx_ff[2] == idx_ff[0]) || (idx_ff[2] == idx_ff[1])));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      vcount_in = vcount_ff;
      fcount_in = fcount_ff;
      v_in      = v_ff;
      f_in      = f_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      wait_in   = wait_ff;
      err_in    = err_ff;
      more_in   = more_ff;
      idx_in    = idx_ff;
      p0_in     = p0_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      c_in      = c_ff;
      a_in      = a_ff;
      m_in      = m_ff;
      neg_in    = neg_ff;
      sq_in     = sq_ff;
      len_in    = len_ff;
      u_in      = u_ff;
      sum_in    = sum_ff;
      n_in      = n_ff;
      rc_in     = rc_ff;
      rn_in     = rn_ff;
      rl_in     = rl_ff;
      rd_in     = rd_ff;
      re_in     = re_ff;

      pos_we = 1'b0; pos_waddr = VW'(req_slot); pos_wdata = {req_pos_x, req_pos_y, req_pos_z};
      pos_re = 1'b0; pos_raddr = '0;
      face_we = 1'b0; face_waddr = FW'(req_slot);
      face_wdata = {req_corner_a, req_corner_b, req_corner_c};
      face_re = 1'b0; face_raddr = '0;
      acc_we = 1'b0; acc_waddr = '0; acc_wdata = '0;
      acc_re = 1'b0; acc_raddr = '0;
      nrm_we = 1'b0; nrm_waddr = VW'(v_ff); nrm_wdata = '0;
      nrm_re = 1'b0; nrm_raddr = '0;

      alu_ctl.start = 1'b0;
      alu_ctl.op    = ALU_MUL;
      mul_a = '0;
      mul_b = '0;
      dvd   = '0;
      dvs   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_LOAD_POS: begin
                     if (32'(req_slot) < MAX_VERTS) begin
                        pos_we = 1'b1;
                        if (32'(vcount_ff) <= 32'(req_slot)) begin
                           vcount_in = VCW'(32'(req_slot) + 1);
                        end
                     end
                  end
                  CMD_LOAD_FACE: begin
                     if (32'(req_slot) < MAX_FACES) begin
                        face_we = 1'b1;
                        if (32'(fcount_ff) <= 32'(req_slot)) begin
                           fcount_in = FCW'(32'(req_slot) + 1);
                        end
                     end
                  end
                  CMD_COMPUTE: begin
                     err_in   = 1'b0;
                     v_in     = '0;
                     state_in = ST_CLR;
                  end
                  CMD_READ: begin
                     if (32'(req_slot) < 32'(fcount_ff)) begin
                        face_re    = 1'b1;
                        face_raddr = FW'(req_slot);
                        state_in   = ST_R_FACE;
                     end else begin
                        rc_in    = '0;
                        rn_in    = '{default: '0};
                        rl_in    = 1'b1;
                        rd_in    = 1'b0;
                        re_in    = 1'b1;
                        more_in  = 1'b0;
                        state_in = ST_RSP;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // zero the accumulators of all loaded vertices
         ST_CLR: begin
            if (v_ff == vcount_ff) begin
               f_in     = '0;
               state_in = ST_F_ISSUE;
            end else begin
               acc_we    = 1'b1;
               acc_waddr = VW'(v_ff);
               v_in      = v_ff + 1'b1;
            end
         end

         ST_F_ISSUE: begin
            if (f_ff == fcount_ff) begin
               v_in     = '0;
               state_in = ST_V_ISSUE;
            end else begin
               face_re    = 1'b1;
               face_raddr = FW'(f_ff);
               state_in   = ST_F_WAIT;
            end
         end

         ST_F_WAIT: begin
            idx_in = fc;
            if (bad) begin
               err_in   = 1'b1;
               f_in     = f_ff + 1'b1;
               state_in = ST_F_ISSUE;
            end else begin
               pos_re    = 1'b1;
               pos_raddr = VW'(fc[0]);
               k_in      = 2'd1;
               state_in  = ST_P_READ;
            end
         end

         // fetch the three corners, forming both edges on the fly
         ST_P_READ: begin
            case (k_ff)
               2'd1: begin
                  p0_in     = pv;
                  pos_re    = 1'b1;
                  pos_raddr = VW'(idx_ff[1]);
                  k_in      = 2'd2;
               end
               2'd2: begin
                  for (int i = 0; i < 3; i++) e1_in[i] = EDGE_W'(p0_ff[i]) - EDGE_W'(pv[i]);
                  pos_re    = 1'b1;
                  pos_raddr = VW'(idx_ff[2]);
                  k_in      = 2'd3;
               end
               default: begin
                  for (int i = 0; i < 3; i++) e2_in[i] = EDGE_W'(p0_ff[i]) - EDGE_W'(pv[i]);
                  j_in     = '0;
                  state_in = ST_MUL;
               end
            endcase
         end

         // six products of the cross product, one per cycle
         ST_MUL: begin
            alu_ctl.start = (j_ff < 3'd6);
            case (j_ff)
               3'd0: begin mul_a = MUL_W'(e1_ff[1]); mul_b = MUL_W'(e2_ff[2]); end
               3'd1: begin mul_a = MUL_W'(e1_ff[2]); mul_b = MUL_W'(e2_ff[1]); end
               3'd2: begin mul_a = MUL_W'(e1_ff[2]); mul_b = MUL_W'(e2_ff[0]); end
               3'd3: begin mul_a = MUL_W'(e1_ff[0]); mul_b = MUL_W'(e2_ff[2]); end
               3'd4: begin mul_a = MUL_W'(e1_ff[0]); mul_b = MUL_W'(e2_ff[1]); end
               3'd5: begin mul_a = MUL_W'(e1_ff[1]); mul_b = MUL_W'(e2_ff[0]); end
               default: ;
            endcase
            case (j_ff)
               3'd1: c_in[0] = pc;
               3'd2: c_in[0] = c_ff[0] - pc;
               3'd3: c_in[1] = pc;
               3'd4: c_in[1] = c_ff[1] - pc;
               3'd5: c_in[2] = pc;
               3'd6: c_in[2] = c_ff[2] - pc;
               default: ;
            endcase
            j_in = j_ff + 1'b1;
            if (j_ff == 3'd6) state_in = ST_ABS;
         end

         ST_ABS: begin
            for (int i = 0; i < 3; i++) neg_in[i] = c_ff[i][CROSS_W-1];
            a_in = ca;
            m_in = m_new;
            if (m_new == '0) begin
               u_in     = '{default: '0};
               k_in     = 2'd0;
               state_in = ST_ACC_RD;
            end else begin
               state_in = ST_NORM;
            end
         end

         // one bit of scaling per cycle into [2^19, 2^20)
         ST_NORM: begin
            if (m_ff[ABS_W-1:NRM_TOP] != '0) begin
               m_in = m_ff >> 1;
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] >> 1;
            end else if (!m_ff[NRM_TOP-1]) begin
               m_in = m_ff << 1;
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] << 1;
            end else begin
               sq_in    = '0;
               j_in     = '0;
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            alu_ctl.start = (j_ff < 3'd3);
            mul_a = $signed({1'b0, a_sel[MUL_W-2:0]});
            mul_b = $signed({1'b0, a_sel[MUL_W-2:0]});
            if (j_ff != 3'd0) sq_in = sq_ff + SQ_W'($unsigned(prod));
            j_in = j_ff + 1'b1;
            if (j_ff == 3'd3) begin
               wait_in  = 1'b0;
               state_in = ST_SQRT;
            end
         end

         ST_SQRT: begin
            if (!wait_ff) begin
               alu_ctl.start = 1'b1;
               alu_ctl.op    = ALU_SQRT;
               wait_in       = 1'b1;
            end else if (alu_done) begin
               len_in   = root;
               wait_in  = 1'b0;
               j_in     = '0;
               state_in = ST_DIVF;
            end
         end

         // unit component = round(a * 2^14 / len)
         ST_DIVF: begin
            dvd = DVD_W'({a_sel, {FRAC_W{1'b0}}}) + DVD_W'(len_ff >> 1);
            dvs = DVS_W'(len_ff);
            if (!wait_ff) begin
               alu_ctl.start = 1'b1;
               alu_ctl.op    = ALU_DIV;
               wait_in       = 1'b1;
            end else if (alu_done) begin
               u_in[j_ff[1:0]] = qv;
               wait_in         = 1'b0;
               j_in            = j_ff + 1'b1;
               if (j_ff == 3'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_ACC_RD;
               end
            end
         end

         // add the unit normal into each distinct corner
         ST_ACC_RD: begin
            if (k_ff == 2'd3) begin
               f_in     = f_ff + 1'b1;
               state_in = ST_F_ISSUE;
            end else if (dup) begin
               k_in = k_ff + 1'b1;
            end else begin
               acc_re    = 1'b1;
               acc_raddr = VW'(idx_sel);
               state_in  = ST_ACC_WR;
            end
         end

         ST_ACC_WR: begin
            acc_we    = 1'b1;
            acc_waddr = VW'(idx_sel);
            acc_wdata = {as[0] + SUMW'(u_ff[0]), as[1] + SUMW'(u_ff[1]),
                         as[2] + SUMW'(u_ff[2]), an + 1'b1};
            k_in      = k_ff + 1'b1;
            state_in  = ST_ACC_RD;
         end

         // per-vertex averaging
         ST_V_ISSUE: begin
            if (v_ff == vcount_ff) begin
               rc_in    = '0;
               rn_in    = '{default: '0};
               rl_in    = 1'b1;
               rd_in    = 1'b1;
               re_in    = err_ff;
               more_in  = 1'b0;
               state_in = ST_RSP;
            end else begin
               acc_re    = 1'b1;
               acc_raddr = VW'(v_ff);
               state_in  = ST_V_WAIT;
            end
         end

         ST_V_WAIT: begin
            sum_in = as;
            n_in   = an;
            if (an == '0) begin
               nrm_we   = 1'b1;
               v_in     = v_ff + 1'b1;
               state_in = ST_V_ISSUE;
            end else begin
               j_in     = '0;
               wait_in  = 1'b0;
               state_in = ST_V_DIV;
            end
         end

         ST_V_DIV: begin
            dvd = DVD_W'(s_abs) + DVD_W'(n_ff >> 1);
            dvs = DVS_W'(n_ff);
            if (!wait_ff) begin
               alu_ctl.start = 1'b1;
               alu_ctl.op    = ALU_DIV;
               wait_in       = 1'b1;
            end else if (alu_done) begin
               u_in[j_ff[1:0]] = s_sel[SUMW-1] ? -qs : qs;
               wait_in         = 1'b0;
               j_in            = j_ff + 1'b1;
               if (j_ff == 3'd2) begin
                  nrm_we    = 1'b1;
                  nrm_wdata = {u_ff[0], u_ff[1], s_sel[SUMW-1] ? -qs : qs};
                  v_in      = v_ff + 1'b1;
                  state_in  = ST_V_ISSUE;
               end
            end
         end

         // face read, one corner per beat
         ST_R_FACE: begin
            idx_in   = fc;
            k_in     = 2'd0;
            state_in = ST_R_ISSUE;
         end

         ST_R_ISSUE: begin
            if (32'(idx_sel) >= 32'(vcount_ff)) begin
               rc_in    = k_ff;
               rn_in    = '{default: '0};
               rl_in    = (k_ff == 2'd2);
               rd_in    = 1'b0;
               re_in    = 1'b1;
               more_in  = (k_ff != 2'd2);
               state_in = ST_RSP;
            end else begin
               nrm_re    = 1'b1;
               nrm_raddr = VW'(idx_sel);
               state_in  = ST_R_WAIT;
            end
         end

         ST_R_WAIT: begin
            rc_in    = k_ff;
            for (int i = 0; i < 3; i++) rn_in[i] = nrm_rdata[NW-1-i*NORM_W -: NORM_W];
            rl_in    = (k_ff == 2'd2);
            rd_in    = 1'b0;
            re_in    = 1'b0;
            more_in  = (k_ff != 2'd2);
            state_in = ST_RSP;
         end

         ST_RSP: begin
            if (rsp_ready) begin
               if (more_ff) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_R_ISSUE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= '0;
         fcount_ff <= '0;
         wait_ff   <= 1'b0;
         err_ff    <= 1'b0;
         more_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         fcount_ff <= fcount_in;
         wait_ff   <= wait_in;
         err_ff    <= err_in;
         more_ff   <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      f_ff   <= f_in;
      k_ff   <= k_in;
      j_ff   <= j_in;
      idx_ff <= idx_in;
      p0_ff  <= p0_in;
      e1_ff  <= e1_in;
      e2_ff  <= e2_in;
      c_ff   <= c_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
      neg_ff <= neg_in;
      sq_ff  <= sq_in;
      len_ff <= len_in;
      u_ff   <= u_in;
      sum_ff <= sum_in;
      n_ff   <= n_in;
      rc_ff  <= rc_in;
      rn_ff  <= rn_in;
      rl_ff  <= rl_in;
      rd_ff  <= rd_in;
      re_ff  <= re_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RSP);
   assign rsp_corner   = rc_ff;
   assign rsp_norm_x   = rn_ff[0];
   assign rsp_norm_y   = rn_ff[1];
   assign rsp_norm_z   = rn_ff[2];
   assign rsp_last     = rl_ff;
   assign rsp_done_res = rd_ff;
   assign rsp_error    = re_ff;

endmodule
